FILE: design/csm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_pkg: shared definitions for the CSR sparse matrix-vector block
// Request codes, store and queue sizing, and the structs passed between units.
// ----------------------------------------------------------------------------
package csm_pkg;

    // Dense-vector store
    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);

    // Row counter wraps modulo MAX_ROWS
    localparam longint unsigned MAX_ROWS = 65536;
    localparam int ROW_CW = $clog2(MAX_ROWS);

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_NZ    = 2'd1;
    localparam logic [1:0] REQ_EMPTY = 2'd2;

    // Q32.32 limits
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    // One finished row
    typedef struct packed {
        logic signed [63:0] row_sum;
        logic [15:0]        row_number;
        logic               saturated;
    } csm_result_t;

    // Row-ending items still inside the datapath
    typedef struct packed {
        logic p1_pend;
        logic p2_pend;
    } csm_flight_t;

endpackage

FILE: design/csr_sparse_matvec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_matvec: CSR sparse matrix times dense vector
// Streams loads, nonzeros and empty rows; emits one Q32.32 sum per row.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while s_ready is high. A finished
// row passes the stage 1 and stage 2 registers, is written into the result
// queue and is offered on the m_ side once it is queued.
// Throughput is set by the single-port 1024 x 32 vector store, which serves
// exactly one load write or one nonzero read per cycle, followed by one
// 32 x 32 multiplier stage and one 64-bit saturating add stage. Finished rows
// collect in a four-beat queue; s_ready drops only when that queue plus the
// row ends still in the datapath fill it. The store has no reset and
// no clearing pass: a nonzero must only name a column that was loaded first.
module csr_sparse_matvec import csm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [9:0]         s_vector_index,
    input  logic signed [31:0] s_element_value,
    input  logic               s_row_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_row_sum,
    output logic [15:0]        m_row_number,
    output logic               m_sum_saturated
);

    logic               in_fire;
    logic               push;
    csm_result_t        push_data;
    csm_flight_t        flight;
    csm_result_t        head;
    logic [FIFO_CW-1:0] count;
    logic [FIFO_CW-1:0] committed;

    assign in_fire = s_valid && s_ready;

    csm_mac u_mac (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .req_type      (s_req_type),
        .vector_index  (s_vector_index),
        .element_value (s_element_value),
        .row_last      (s_row_last),
        .push          (push),
        .push_data     (push_data),
        .flight        (flight)
    );

    csm_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_valid && m_ready),
        .head      (head),
        .count     (count)
    );

    // Credit: queued rows plus row ends still in flight
    assign committed = count + FIFO_CW'(flight.p1_pend) + FIFO_CW'(flight.p2_pend);
    assign s_ready   = committed < FIFO_CW'(FIFO_DEPTH);

    assign m_valid         = (count != '0);
    assign m_row_sum       = head.row_sum;
    assign m_row_number    = head.row_number;
    assign m_sum_saturated = head.saturated;

endmodule

FILE: design/csm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_mac: vector store and multiply-accumulate datapath
// Loads write the store; nonzeros read it, multiply and accumulate with
// saturation; row ends push one result beat towards the output queue.
// ----------------------------------------------------------------------------
module csm_mac import csm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic [1:0]         req_type,
    input  logic [9:0]         vector_index,
    input  logic signed [31:0] element_value,
    input  logic               row_last,
    output logic               push,
    output csm_result_t        push_data,
    output csm_flight_t        flight
);

    // Vector store, one access per cycle, registered read
    logic [31:0]        vec_mem [VEC_DEPTH];
    logic signed [31:0] rd_data_reg;

    logic              idx_ok;
    logic [VEC_AW-1:0] addr;
    logic              is_nz;
    logic              is_empty;

    assign idx_ok   = 32'(vector_index) < 32'(VEC_DEPTH);
    assign addr     = VEC_AW'(vector_index);
    assign is_nz    = (req_type == REQ_NZ);
    assign is_empty = (req_type == REQ_EMPTY);

    always_ff @(posedge aclk) begin
        if (in_fire && (req_type == REQ_LOAD) && idx_ok) begin
            vec_mem[addr] <= element_value;
        end
        if (in_fire && is_nz) begin
            rd_data_reg <= vec_mem[addr];
        end
    end

    // Stage 1: item waits for the store read
    logic               p1_valid_reg, p1_valid_next;
    logic               p1_nz_reg;
    logic               p1_ok_reg;
    logic               p1_end_reg;
    logic signed [31:0] p1_val_reg;

    assign p1_valid_next = in_fire && (is_nz || is_empty);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
        p1_nz_reg  <= is_nz;
        p1_ok_reg  <= idx_ok;
        p1_end_reg <= is_empty || (is_nz && row_last);
        p1_val_reg <= element_value;
    end

    // Stage 2: exact Q32.32 product, zero for empty rows and far columns
    logic               p2_valid_reg;
    logic               p2_end_reg;
    logic signed [63:0] prod_reg, prod_next;

    always_comb begin
        if (p1_nz_reg && p1_ok_reg) begin
            prod_next = 64'(p1_val_reg) * 64'(rd_data_reg);
        end else begin
            prod_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
        end
        p2_end_reg <= p1_end_reg;
        prod_reg   <= prod_next;
    end

    // Stage 3: saturating accumulate and row close
    logic signed [63:0] acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic [ROW_CW-1:0]  cnt_reg, cnt_next;
    logic signed [63:0] sum;
    logic signed [63:0] sat_sum;
    logic               add_ovf;

    assign sum     = acc_reg + prod_reg;
    assign add_ovf = (acc_reg[63] == prod_reg[63]) && (sum[63] != acc_reg[63]);
    assign sat_sum = add_ovf ? (acc_reg[63] ? ACC_MIN : ACC_MAX) : sum;

    always_comb begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        if (p2_valid_reg) begin
            if (p2_end_reg) begin
                acc_next = '0;
                ovf_next = 1'b0;
                cnt_next = (cnt_reg == ROW_CW'(MAX_ROWS - 1)) ? '0 : cnt_reg + 1'b1;
            end else begin
                acc_next = sat_sum;
                ovf_next = ovf_reg | add_ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
            cnt_reg <= cnt_next;
        end
    end

    assign push                 = p2_valid_reg && p2_end_reg;
    assign push_data.row_sum    = sat_sum;
    assign push_data.row_number = 16'(cnt_reg);
    assign push_data.saturated  = ovf_reg | add_ovf;

    assign flight.p1_pend = p1_valid_reg && p1_end_reg;
    assign flight.p2_pend = p2_valid_reg && p2_end_reg;

endmodule

FILE: design/csm_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_out_fifo: result queue
// Small register queue that holds finished rows until the sink takes them.
// ----------------------------------------------------------------------------
module csm_out_fifo import csm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  csm_result_t        push_data,
    input  logic               pop,
    output csm_result_t        head,
    output logic [FIFO_CW-1:0] count
);

    csm_result_t        q_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;

    // Storage; the credit check upstream keeps pushes off a full queue
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head  = q_mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

FILE: design/csm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_checker: port-level checks for csr_sparse_matvec
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module csm_checker import csm_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_req_type,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_row_sum,
    input logic [15:0]        m_row_number,
    input logic               m_sum_saturated
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat offered straight after reset");

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_sum)
                                && $stable(m_row_number) && $stable(m_sum_saturated))
        else $error("stalled result beat changed");

    // An empty queue never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result queued");

    // An empty-row beat yields a result within the datapath latency
    a_empty_row_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_EMPTY) |-> ##3 m_valid)
        else $error("empty row produced no result");

endmodule

bind csr_sparse_matvec csm_checker u_csm_checker (.*);
